// ===== rtl/tqp_pkg.sv =====
`default_nettype none

package tqp_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam logic [31:0] CAP_RESET = 32'd67108864;
    localparam logic [15:0] REFS_MAX = 16'hFFFF;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = '0;

    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_MISMATCH    = 3'd2,
        ST_TOO_LARGE   = 3'd3,
        ST_NO_SPACE    = 3'd4,
        ST_RELEASED    = 3'd5,
        ST_REL_IGNORED = 3'd6,
        ST_EVICTED     = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_EVCHK,
        S_VSCAN,
        S_VPICK,
        S_EVICT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  kind;
        logic [31:0] bytes;
    } slot_word_t;

endpackage

`default_nettype wire

// ===== rtl/tqp_if.sv =====
`default_nettype none

interface tqp_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] key;
    logic [1:0]  type_tag;
    logic [31:0] size_bytes;

    modport source (output valid, func, key, type_tag, size_bytes, input ready);
    modport sink (input valid, func, key, type_tag, size_bytes, output ready);
endinterface

interface tqp_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] evicted_key;
    logic [15:0] pin_count;
    logic [31:0] bytes_used;
    logic        last;

    modport source (output valid, status, evicted_key, pin_count, bytes_used, last,
                    input ready);
    modport sink (input valid, status, evicted_key, pin_count, bytes_used, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tqp_slot_mem.sv =====
`default_nettype none

module tqp_slot_mem #(
    parameter int ENTRIES = tqp_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [IW-1:0]       waddr,
    input  wire tqp_pkg::slot_word_t wdata,
    input  wire logic [IW-1:0]       raddr,
    output tqp_pkg::slot_word_t      rdata
);

    tqp_pkg::slot_word_t mem [ENTRIES];
    tqp_pkg::slot_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/two_queue_pinned_cache_policy.sv =====
// The lookup scans every slot, then a hit, release or rejection answers; a miss that needs
// room scans again for a victim before each eviction word, and the insert word follows
// the last eviction handshake. The block takes one request at a time and takes no new
// request until the last result word is taken, so an output stall holds it.
// Reset empties the directory at once through per-slot valid flops; no clearing pass.
`default_nettype none

module two_queue_pinned_cache_policy #(
    parameter int ENTRIES = tqp_pkg::ENTRIES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    tqp_req_if.sink                         req,
    tqp_rsp_if.source                       rsp,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tqp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = $clog2(ENTRIES);
    localparam logic [CW-1:0] N_CNT = CW'(ENTRIES);
    localparam logic [CW-1:0] N_LAST = CW'(ENTRIES - 1);

    tqp_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] cnt_reg, cnt_next, count_reg, count_next;
    logic [31:0]   cap_reg, total_reg, total_next;
    logic [ENTRIES-1:0] valid_reg, valid_next, main_reg, main_next;
    logic [RW-1:0] rank_reg [ENTRIES];
    logic [RW-1:0] rank_next [ENTRIES];
    logic [15:0]   refs_reg [ENTRIES];
    logic [15:0]   refs_next [ENTRIES];

    logic        func_reg;
    logic [63:0] key_reg;
    logic [1:0]  kind_reg;
    logic [31:0] size_reg;

    logic          found_reg, found_next;
    logic [IW-1:0] s_reg, s_next, free_reg, free_next, v_reg, v_next;
    logic [1:0]    s_kind_reg, s_kind_next;
    logic          bm_ok_reg, bm_ok_next, bf_ok_reg, bf_ok_next;
    logic [IW-1:0] bm_idx_reg, bm_idx_next, bf_idx_reg, bf_idx_next;
    logic [RW-1:0] bm_rank_reg, bm_rank_next, bf_rank_reg, bf_rank_next;
    logic          chk_en_reg, chk_en_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;

    logic             o_valid_reg, o_valid_next;
    tqp_pkg::status_t o_status_reg, o_status_next;
    logic [63:0]      o_key_reg, o_key_next;
    logic [15:0]      o_refs_reg, o_refs_next;
    logic [31:0]      o_bytes_reg, o_bytes_next;
    logic             o_last_reg, o_last_next;

    logic                mem_we;
    logic [IW-1:0]       mem_raddr;
    tqp_pkg::slot_word_t mem_wdata, mem_rdata;

    logic          emit;
    logic [15:0]   refs_s;
    logic [IW-1:0] scan_j;
    logic          need_evict;

    tqp_slot_mem #(.ENTRIES(ENTRIES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (free_reg),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready       = (state_reg == tqp_pkg::S_IDLE);
    assign rsp.valid       = o_valid_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.evicted_key = o_key_reg;
    assign rsp.pin_count   = o_refs_reg;
    assign rsp.bytes_used  = o_bytes_reg;
    assign rsp.last        = o_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == tqp_pkg::ADDR_CAPACITY) ? cap_reg : 32'd0;

    assign mem_wdata = '{key: key_reg, kind: kind_reg, bytes: size_reg};
    assign refs_s = refs_reg[s_reg];
    assign scan_j = cnt_reg[IW-1:0];
    assign need_evict = ({1'b0, total_reg} + {1'b0, size_reg} > {1'b0, cap_reg}) ||
                        (count_reg == N_CNT);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cnt_next      = cnt_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        valid_next    = valid_reg;
        main_next     = main_reg;
        rank_next     = rank_reg;
        refs_next     = refs_reg;
        found_next    = found_reg;
        s_next        = s_reg;
        s_kind_next   = s_kind_reg;
        free_next     = free_reg;
        v_next        = v_reg;
        bm_ok_next    = bm_ok_reg;
        bm_idx_next   = bm_idx_reg;
        bm_rank_next  = bm_rank_reg;
        bf_ok_next    = bf_ok_reg;
        bf_idx_next   = bf_idx_reg;
        bf_rank_next  = bf_rank_reg;
        chk_en_next   = 1'b0;
        chk_idx_next  = cnt_reg[IW-1:0];
        o_valid_next  = o_valid_reg;
        o_status_next = o_status_reg;
        o_key_next    = o_key_reg;
        o_refs_next   = o_refs_reg;
        o_bytes_next  = o_bytes_reg;
        o_last_next   = o_last_reg;
        mem_we        = 1'b0;
        mem_raddr     = cnt_reg[IW-1:0];
        emit          = 1'b0;

        case (state_reg)
            tqp_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = tqp_pkg::S_FIND;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end

            tqp_pkg::S_FIND:
            begin
                // The memory word arrives in the cycle after its address.
                chk_en_next = (cnt_reg != N_CNT);
                if (chk_en_reg)
                begin
                    if (valid_reg[chk_idx_reg])
                    begin
                        if (!found_reg && mem_rdata.key == key_reg)
                        begin
                            found_next  = 1'b1;
                            s_next      = chk_idx_reg;
                            s_kind_next = mem_rdata.kind;
                        end
                    end
                    else
                    begin
                        free_next = chk_idx_reg;
                    end
                end
                if (cnt_reg == N_CNT)
                begin
                    state_next = tqp_pkg::S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tqp_pkg::S_DECIDE:
            begin
                if (func_reg)
                begin
                    emit        = 1'b1;
                    ret_next    = tqp_pkg::S_IDLE;
                    o_last_next = 1'b1;
                    o_key_next  = '0;
                    if (found_reg && refs_s != 16'd0)
                    begin
                        refs_next[s_reg] = refs_s - 1'b1;
                        o_status_next    = tqp_pkg::ST_RELEASED;
                        o_refs_next      = refs_s - 1'b1;
                    end
                    else
                    begin
                        o_status_next = tqp_pkg::ST_REL_IGNORED;
                        o_refs_next   = found_reg ? refs_s : 16'd0;
                    end
                end
                else if (found_reg)
                begin
                    emit        = 1'b1;
                    ret_next    = tqp_pkg::S_IDLE;
                    o_last_next = 1'b1;
                    o_key_next  = '0;
                    if (s_kind_reg != kind_reg)
                    begin
                        o_status_next = tqp_pkg::ST_MISMATCH;
                        o_refs_next   = refs_s;
                    end
                    else
                    begin
                        // Close the gap in the old queue, then open the main head.
                        for (int j = 0; j < ENTRIES; j++)
                        begin
                            if (valid_reg[j] && j != int'(s_reg))
                            begin
                                rank_next[j] = rank_reg[j]
                                    - RW'(main_reg[j] == main_reg[s_reg] &&
                                          rank_reg[j] > rank_reg[s_reg])
                                    + RW'(main_reg[j]);
                            end
                        end
                        refs_next[s_reg] = (refs_s == tqp_pkg::REFS_MAX) ? refs_s
                                                                         : refs_s + 1'b1;
                        main_next[s_reg] = 1'b1;
                        rank_next[s_reg] = '0;
                        o_status_next    = tqp_pkg::ST_HIT;
                        o_refs_next      = (refs_s == tqp_pkg::REFS_MAX) ? refs_s
                                                                         : refs_s + 1'b1;
                    end
                end
                else if (size_reg > cap_reg)
                begin
                    emit          = 1'b1;
                    ret_next      = tqp_pkg::S_IDLE;
                    o_last_next   = 1'b1;
                    o_key_next    = '0;
                    o_status_next = tqp_pkg::ST_TOO_LARGE;
                    o_refs_next   = '0;
                end
                else
                begin
                    state_next = tqp_pkg::S_EVCHK;
                end
            end

            tqp_pkg::S_EVCHK:
            begin
                if (need_evict)
                begin
                    state_next = tqp_pkg::S_VSCAN;
                    cnt_next   = '0;
                    bm_ok_next = 1'b0;
                    bf_ok_next = 1'b0;
                end
                else
                begin
                    for (int j = 0; j < ENTRIES; j++)
                    begin
                        if (valid_reg[j] && !main_reg[j])
                        begin
                            rank_next[j] = rank_reg[j] + 1'b1;
                        end
                    end
                    valid_next[free_reg] = 1'b1;
                    main_next[free_reg]  = 1'b0;
                    rank_next[free_reg]  = '0;
                    refs_next[free_reg]  = 16'd1;
                    mem_we               = 1'b1;
                    total_next           = total_reg + size_reg;
                    count_next           = count_reg + 1'b1;
                    emit                 = 1'b1;
                    ret_next             = tqp_pkg::S_IDLE;
                    o_last_next          = 1'b1;
                    o_key_next           = '0;
                    o_status_next        = tqp_pkg::ST_INSERTED;
                    o_refs_next          = 16'd1;
                end
            end

            tqp_pkg::S_VSCAN:
            begin
                if (valid_reg[scan_j] && refs_reg[scan_j] == 16'd0)
                begin
                    if (main_reg[scan_j])
                    begin
                        if (!bm_ok_reg || rank_reg[scan_j] > bm_rank_reg)
                        begin
                            bm_ok_next   = 1'b1;
                            bm_idx_next  = scan_j;
                            bm_rank_next = rank_reg[scan_j];
                        end
                    end
                    else if (!bf_ok_reg || rank_reg[scan_j] > bf_rank_reg)
                    begin
                        bf_ok_next   = 1'b1;
                        bf_idx_next  = scan_j;
                        bf_rank_next = rank_reg[scan_j];
                    end
                end
                if (cnt_reg == N_LAST)
                begin
                    state_next = tqp_pkg::S_VPICK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tqp_pkg::S_VPICK:
            begin
                if (bm_ok_reg || bf_ok_reg)
                begin
                    v_next     = bm_ok_reg ? bm_idx_reg : bf_idx_reg;
                    mem_raddr  = bm_ok_reg ? bm_idx_reg : bf_idx_reg;
                    state_next = tqp_pkg::S_EVICT;
                end
                else
                begin
                    // Every entry is pinned: earlier evictions stand.
                    emit          = 1'b1;
                    ret_next      = tqp_pkg::S_IDLE;
                    o_last_next   = 1'b1;
                    o_key_next    = '0;
                    o_status_next = tqp_pkg::ST_NO_SPACE;
                    o_refs_next   = '0;
                end
            end

            tqp_pkg::S_EVICT:
            begin
                valid_next[v_reg] = 1'b0;
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (valid_reg[j] && j != int'(v_reg) &&
                        main_reg[j] == main_reg[v_reg] && rank_reg[j] > rank_reg[v_reg])
                    begin
                        rank_next[j] = rank_reg[j] - 1'b1;
                    end
                end
                total_next = (total_reg >= mem_rdata.bytes) ? total_reg - mem_rdata.bytes
                                                            : 32'd0;
                count_next    = count_reg - 1'b1;
                free_next     = v_reg;
                emit          = 1'b1;
                ret_next      = tqp_pkg::S_EVCHK;
                o_last_next   = 1'b0;
                o_key_next    = mem_rdata.key;
                o_status_next = tqp_pkg::ST_EVICTED;
                o_refs_next   = '0;
            end

            tqp_pkg::S_OUT:
            begin
                if (rsp.ready)
                begin
                    o_valid_next = 1'b0;
                    state_next   = ret_reg;
                end
            end

            default:
            begin
                state_next = tqp_pkg::S_IDLE;
            end
        endcase

        if (emit)
        begin
            o_valid_next = 1'b1;
            o_bytes_next = total_next;
            state_next   = tqp_pkg::S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tqp_pkg::S_IDLE;
            ret_reg     <= tqp_pkg::S_IDLE;
            cnt_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            cap_reg     <= tqp_pkg::CAP_RESET;
            valid_reg   <= '0;
            found_reg   <= 1'b0;
            bm_ok_reg   <= 1'b0;
            bf_ok_reg   <= 1'b0;
            chk_en_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            valid_reg   <= valid_next;
            found_reg   <= found_next;
            bm_ok_reg   <= bm_ok_next;
            bf_ok_reg   <= bf_ok_next;
            chk_en_reg  <= chk_en_next;
            o_valid_reg <= o_valid_next;
            if (psel && penable && pwrite && paddr == tqp_pkg::ADDR_CAPACITY)
            begin
                cap_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            key_reg  <= req.key;
            kind_reg <= req.type_tag;
            size_reg <= req.size_bytes;
        end
        main_reg     <= main_next;
        rank_reg     <= rank_next;
        refs_reg     <= refs_next;
        s_reg        <= s_next;
        s_kind_reg   <= s_kind_next;
        free_reg     <= free_next;
        v_reg        <= v_next;
        bm_idx_reg   <= bm_idx_next;
        bm_rank_reg  <= bm_rank_next;
        bf_idx_reg   <= bf_idx_next;
        bf_rank_reg  <= bf_rank_next;
        chk_idx_reg  <= chk_idx_next;
        o_status_reg <= o_status_next;
        o_key_reg    <= o_key_next;
        o_refs_reg   <= o_refs_next;
        o_bytes_reg  <= o_bytes_next;
        o_last_reg   <= o_last_next;
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count disagrees with valid flags");

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while a result word is pending");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == tqp_pkg::S_FIND && cnt_reg == '0))
        else $error("accepted request did not start a lookup scan");

    a_evict_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tqp_pkg::S_EVICT) |=> !valid_reg[$past(v_reg)])
        else $error("evicted slot still valid");

endmodule

`default_nettype wire
